// File: sv/xld_pkg.sv
// ----------------------------------------------------------------------------
// xld_pkg
// Shared types and codes for the xor-linked deque: command and result beats,
// operation and status codes, sequencer states and memory write controls.
// ----------------------------------------------------------------------------
package xld_pkg;

  // default sizing
  localparam int DEF_NODES      = 255;
  localparam int DEF_DATA_WIDTH = 32;

  // operation codes
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_CLEAR      = 3'd4;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // command beat
  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] value;
  } xld_cmd_t;

  // result beat
  typedef struct packed {
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic               is_empty;
    logic               is_full;
    logic [7:0]         element_count;
    logic [1:0]         status;
  } xld_result_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_LINK,
    S_POP1,
    S_POP2
  } xld_state_t;

  // node memory write controls
  typedef struct packed {
    logic value_we;
    logic link_we;
  } xld_node_wr_t;

endpackage

// File: sv/xld_node_mem.sv
// ----------------------------------------------------------------------------
// xld_node_mem
// Node memory: value and xor link of each pool node, one write address and
// one read address per cycle, registered read data.
// ----------------------------------------------------------------------------
module xld_node_mem
  import xld_pkg::*;
#(
  parameter int NODES      = DEF_NODES,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  localparam int IW        = $clog2(NODES + 1)
) (
  input  logic                  clk,
  input  xld_node_wr_t          wr,
  input  logic [IW-1:0]         waddr,
  input  logic [DATA_WIDTH-1:0] wvalue,
  input  logic [IW-1:0]         wlink,
  input  logic [IW-1:0]         raddr,
  output logic [DATA_WIDTH-1:0] rvalue,
  output logic [IW-1:0]         rlink
);

  logic [DATA_WIDTH-1:0] values [0:NODES];
  logic [IW-1:0]         links  [0:NODES];

  // write port
  always_ff @(posedge clk) begin
    if (wr.value_we) begin
      values[waddr] <= wvalue;
    end
    if (wr.link_we) begin
      links[waddr] <= wlink;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rvalue <= values[raddr];
    rlink  <= links[raddr];
  end

endmodule

// File: sv/xld_free_stack.sv
// ----------------------------------------------------------------------------
// xld_free_stack
// Stack memory of released node indices; the top pointer lives in the
// sequencer, this holds the entries.
// ----------------------------------------------------------------------------
module xld_free_stack
  import xld_pkg::*;
#(
  parameter int NODES = DEF_NODES,
  localparam int IW   = $clog2(NODES + 1),
  localparam int FW   = $clog2(NODES)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [FW-1:0] waddr,
  input  logic [IW-1:0] wdata,
  input  logic [FW-1:0] raddr,
  output logic [IW-1:0] rdata
);

  logic [IW-1:0] entries [0:NODES-1];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      entries[waddr] <= wdata;
    end
    rdata <= entries[raddr];
  end

endmodule

// File: sv/xor_linked_deque.sv
// ----------------------------------------------------------------------------
// xor_linked_deque
// Double-ended queue kept as an xor-linked list in a pool of NODES nodes.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat (operation, value) is taken at a rising edge where start
//   is high and busy is low. Exactly one result beat follows: done is high
//   for one cycle and result carries front and back values, empty and full
//   flags, the element count and a status code.
//   A push onto a non-empty list steps through S_PUSH and S_LINK, and a pop
//   that leaves a neighbor through S_POP1 and S_POP2, before done; a push onto
//   an empty list ends in S_PUSH and a pop of the last element in S_POP1.
//   Clear, unknown codes, a push when full and a pop when empty are answered
//   from S_IDLE: done is high in the cycle after the accept edge. The next
//   command can be taken at the edge that ends the done cycle. The sequence
//   is set by the registered reads of the node and free-stack memories: a
//   push reads a freed index then rewrites the old end's link, a pop reads
//   the end's link and then the neighbor's link and value.
//   Reset (rst, synchronous) empties the list and the free stack; memory
//   contents are not cleared, no unwritten entry is used.
//   The receiver cannot stall: done marks the only cycle the result is valid.
// ----------------------------------------------------------------------------
module xor_linked_deque
  import xld_pkg::*;
#(
  parameter int NODES      = DEF_NODES,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  xld_cmd_t    command,
  output logic        done,
  output xld_result_t result
);

  localparam int IW = $clog2(NODES + 1);
  localparam int FW = $clog2(NODES);

  // sequencer and list registers
  xld_state_t            state, state_next;
  logic                  at_front, at_front_next;
  logic [DATA_WIDTH-1:0] push_val, push_val_next;
  logic [IW-1:0]         old_idx, old_idx_next;
  logic [IW-1:0]         n_idx, n_idx_next;
  logic [IW-1:0]         head, head_next;
  logic [IW-1:0]         tail, tail_next;
  logic [DATA_WIDTH-1:0] head_val, head_val_next;
  logic [DATA_WIDTH-1:0] tail_val, tail_val_next;
  logic [IW-1:0]         count, count_next;
  logic [IW-1:0]         free_top, free_top_next;
  logic [IW:0]           next_fresh, next_fresh_next;
  logic [1:0]            status, status_next;
  logic                  done_next;

  // memory ports
  xld_node_wr_t          node_wr;
  logic [IW-1:0]         node_waddr;
  logic [DATA_WIDTH-1:0] node_wvalue;
  logic [IW-1:0]         node_wlink;
  logic [IW-1:0]         node_raddr;
  logic [DATA_WIDTH-1:0] node_rvalue;
  logic [IW-1:0]         node_rlink;
  logic                  fs_we;
  logic [FW-1:0]         fs_waddr;
  logic [IW-1:0]         fs_wdata;
  logic [FW-1:0]         fs_raddr;
  logic [IW-1:0]         fs_rdata;

  // helpers
  logic                  accept;
  logic                  cmd_front;
  logic [IW-1:0]         cmd_near;
  logic [IW-1:0]         far_end;
  logic [IW-1:0]         ftop_dec;
  logic [IW-1:0]         taken;
  logic [IW-1:0]         nbr;
  logic [IW-1:0]         nbr_link;
  logic [DATA_WIDTH-1:0] store_val;
  logic [31:0]           front32, back32;

  xld_node_mem #(
    .NODES      (NODES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_node_mem (
    .clk    (clk),
    .wr     (node_wr),
    .waddr  (node_waddr),
    .wvalue (node_wvalue),
    .wlink  (node_wlink),
    .raddr  (node_raddr),
    .rvalue (node_rvalue),
    .rlink  (node_rlink)
  );

  xld_free_stack #(
    .NODES (NODES)
  ) u_free_stack (
    .clk   (clk),
    .we    (fs_we),
    .waddr (fs_waddr),
    .wdata (fs_wdata),
    .raddr (fs_raddr),
    .rdata (fs_rdata)
  );

  // value width adaption on store and read back
  generate
    if (DATA_WIDTH <= 32) begin : g_store_narrow
      assign store_val = command.value[DATA_WIDTH-1:0];
    end else begin : g_store_wide
      assign store_val = {{(DATA_WIDTH-32){command.value[31]}}, command.value};
    end
    if (DATA_WIDTH >= 32) begin : g_read_wide
      assign front32 = head_val[31:0];
      assign back32  = tail_val[31:0];
    end else begin : g_read_narrow
      assign front32 = {{(32-DATA_WIDTH){head_val[DATA_WIDTH-1]}}, head_val};
      assign back32  = {{(32-DATA_WIDTH){tail_val[DATA_WIDTH-1]}}, tail_val};
    end
  endgenerate

  assign accept    = start && (state == S_IDLE);
  assign busy      = (state != S_IDLE);
  assign cmd_front = (command.operation == OP_PUSH_FRONT) ||
                     (command.operation == OP_POP_FRONT);
  assign cmd_near  = cmd_front ? head : tail;
  assign far_end   = at_front ? tail : head;
  assign ftop_dec  = free_top - 1'b1;
  assign taken     = (free_top != '0) ? fs_rdata : next_fresh[IW-1:0];
  assign nbr       = (node_rlink <= IW'(NODES)) ? node_rlink : '0;
  assign nbr_link  = ((node_rlink ^ old_idx) <= IW'(NODES)) ?
                     (node_rlink ^ old_idx) : '0;

  // state and list registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      free_top   <= '0;
      next_fresh <= (IW + 1)'(1);
      status     <= ST_DONE;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      tail       <= tail_next;
      count      <= count_next;
      free_top   <= free_top_next;
      next_fresh <= next_fresh_next;
      status     <= status_next;
      done       <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    at_front <= at_front_next;
    push_val <= push_val_next;
    old_idx  <= old_idx_next;
    n_idx    <= n_idx_next;
    head_val <= head_val_next;
    tail_val <= tail_val_next;
  end

  // sequencer: next state, list update and memory accesses
  always_comb begin
    state_next      = state;
    at_front_next   = at_front;
    push_val_next   = push_val;
    old_idx_next    = old_idx;
    n_idx_next      = n_idx;
    head_next       = head;
    tail_next       = tail;
    head_val_next   = head_val;
    tail_val_next   = tail_val;
    count_next      = count;
    free_top_next   = free_top;
    next_fresh_next = next_fresh;
    status_next     = status;
    done_next       = 1'b0;
    node_wr         = '0;
    node_waddr      = n_idx;
    node_wvalue     = push_val;
    node_wlink      = old_idx;
    node_raddr      = old_idx;
    fs_we           = 1'b0;
    fs_waddr        = free_top[FW-1:0];
    fs_wdata        = old_idx;
    fs_raddr        = ftop_dec[FW-1:0];

    unique case (state)
      S_IDLE: begin
        // read the near end's link and the free stack top ahead of time
        node_raddr = cmd_near;
        if (accept) begin
          at_front_next = cmd_front;
          push_val_next = store_val;
          old_idx_next  = cmd_near;
          status_next   = ST_DONE;
          unique case (command.operation) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (count == IW'(NODES)) begin
                status_next = ST_FULL;
                done_next   = 1'b1;
              end else begin
                state_next = S_PUSH;
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (cmd_near == '0) begin
                status_next = ST_EMPTY;
                done_next   = 1'b1;
              end else begin
                state_next = S_POP1;
              end
            end
            OP_CLEAR: begin
              head_next       = '0;
              tail_next       = '0;
              count_next      = '0;
              free_top_next   = '0;
              next_fresh_next = (IW + 1)'(1);
              done_next       = 1'b1;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      S_PUSH: begin
        // allocate a node, write its value and link, become the near end
        if (free_top != '0) begin
          free_top_next = ftop_dec;
        end else begin
          next_fresh_next = next_fresh + 1'b1;
        end
        node_wr     = '{value_we: 1'b1, link_we: 1'b1};
        node_waddr  = taken;
        node_wvalue = push_val;
        node_wlink  = old_idx;
        n_idx_next  = taken;
        count_next  = count + 1'b1;
        if (at_front) begin
          head_next     = taken;
          head_val_next = push_val;
        end else begin
          tail_next     = taken;
          tail_val_next = push_val;
        end
        if (far_end == '0) begin
          if (at_front) begin
            tail_next     = taken;
            tail_val_next = push_val;
          end else begin
            head_next     = taken;
            head_val_next = push_val;
          end
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          node_raddr = old_idx;
          state_next = S_LINK;
        end
      end

      S_LINK: begin
        // old end gains the new node in its link
        node_wr    = '{value_we: 1'b0, link_we: 1'b1};
        node_waddr = old_idx;
        node_wlink = node_rlink ^ n_idx;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end

      S_POP1: begin
        // release the end node and find its neighbor
        fs_we         = 1'b1;
        fs_waddr      = free_top[FW-1:0];
        fs_wdata      = old_idx;
        free_top_next = free_top + 1'b1;
        count_next    = count - 1'b1;
        n_idx_next    = nbr;
        node_raddr    = nbr;
        if (nbr == '0) begin
          head_next  = '0;
          tail_next  = '0;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_POP2;
        end
      end

      S_POP2: begin
        // neighbor drops the released node and becomes the near end
        node_wr    = '{value_we: 1'b0, link_we: 1'b1};
        node_waddr = n_idx;
        node_wlink = nbr_link;
        if (at_front) begin
          head_next     = n_idx;
          head_val_next = node_rvalue;
        end else begin
          tail_next     = n_idx;
          tail_val_next = node_rvalue;
        end
        done_next  = 1'b1;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // result beat
  always_comb begin
    result.front_value   = (head != '0) ? front32 : '0;
    result.back_value    = (tail != '0) ? back32 : '0;
    result.is_empty      = (head == '0);
    result.is_full       = (count == IW'(NODES));
    result.element_count = 8'(count);
    result.status        = status;
  end

endmodule

// File: sv/xld_checker.sv
// ----------------------------------------------------------------------------
// xld_checker
// Port-level checks for the xor-linked deque, bound to the top level.
// ----------------------------------------------------------------------------
module xld_checker
  import xld_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input xld_cmd_t    command,
  input logic        done,
  input xld_result_t result
);

  // a result beat only appears once the block is free again
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");

  // clear always reports an empty list and success on the next beat
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command.operation == OP_CLEAR) |=>
      (done && result.is_empty && result.status == ST_DONE))
    else $error("clear did not report an empty list");

  // an empty list shows zero values
  assert property (@(posedge clk) disable iff (rst)
    (done && result.is_empty) |->
      (result.front_value == 0 && result.back_value == 0 && !result.is_full))
    else $error("empty list shows stale values");

  // a rejected push means the pool is full
  assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_FULL) |-> result.is_full)
    else $error("push rejected while not full");

  // an ignored pop means the list is empty
  assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_EMPTY) |-> result.is_empty)
    else $error("pop ignored while not empty");

endmodule

bind xor_linked_deque xld_checker u_xld_checker (.*);

// File: dv/xor_linked_deque_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_linked_deque_checker
// Watches the command and result channels of the xor-linked deque. Every
// accepted command beat is applied to a behavioral copy of the deque (node
// pool, free stack, fresh counter, end pointers), which gives the expected
// result beat. Each done beat is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module xor_linked_deque_checker
  import xld_pkg::*;
#(
  parameter int NODES = DEF_NODES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  xld_cmd_t    command,
  input  logic        done,
  input  xld_result_t result,
  output int          failures,
  output int          pending,
  output int          checked,
  output int          full_seen,
  output int          empty_seen
);

  // behavioral deque state
  logic signed [31:0] val_mem  [0:NODES];
  int                 link_mem [0:NODES];
  int                 freed    [0:NODES-1];
  int                 freed_top;
  int                 fresh_idx;
  int                 front_idx;
  int                 back_idx;
  int                 held;

  // result beats still owed by the block, oldest first
  xld_result_t        owed_views [$];
  xld_result_t        oldest_view;

  initial begin
    failures   = 0;
    pending    = 0;
    checked    = 0;
    full_seen  = 0;
    empty_seen = 0;
  end

  task automatic log_mismatch(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    failures = failures + 1;
  endtask

  function automatic void clear_deque();
    freed_top = 0;
    fresh_idx = 1;
    front_idx = 0;
    back_idx  = 0;
    held      = 0;
  endfunction

  // take a node from the free stack, else a fresh one, and link it at one end
  function automatic logic [1:0] push_node(input logic at_front,
                                           input logic signed [31:0] val);
    int n;
    int near_i;
    n = 0;
    if (held >= NODES) return ST_FULL;
    if (freed_top > 0) begin
      freed_top = freed_top - 1;
      n = freed[freed_top];
    end else if (fresh_idx <= NODES) begin
      n = fresh_idx;
      fresh_idx = fresh_idx + 1;
    end else begin
      return ST_FULL;
    end
    near_i = at_front ? front_idx : back_idx;
    val_mem[n]  = val;
    link_mem[n] = near_i;
    if (front_idx == 0) begin
      front_idx = n;
      back_idx  = n;
    end else begin
      link_mem[near_i] = link_mem[near_i] ^ n;
      if (at_front) front_idx = n;
      else back_idx = n;
    end
    held = held + 1;
    return ST_DONE;
  endfunction

  // unlink the end node, fix its neighbor's link and free the node
  function automatic logic [1:0] pop_node(input logic at_front);
    int old;
    int nbr;
    old = at_front ? front_idx : back_idx;
    if (old == 0) return ST_EMPTY;
    nbr = link_mem[old];
    if (nbr == 0) begin
      front_idx = 0;
      back_idx  = 0;
    end else begin
      link_mem[nbr] = link_mem[nbr] ^ old;
      if (at_front) front_idx = nbr;
      else back_idx = nbr;
    end
    if (freed_top < NODES) begin
      freed[freed_top] = old;
      freed_top = freed_top + 1;
    end
    if (held > 0) held = held - 1;
    return ST_DONE;
  endfunction

  // apply one command and return the view of the deque that follows
  function automatic xld_result_t apply_deque_op(input xld_cmd_t cmd);
    xld_result_t view;
    logic [1:0]  st;
    st = ST_DONE;
    case (cmd.operation)
      OP_PUSH_FRONT: st = push_node(1'b1, cmd.value);
      OP_PUSH_BACK:  st = push_node(1'b0, cmd.value);
      OP_POP_FRONT:  st = pop_node(1'b1);
      OP_POP_BACK:   st = pop_node(1'b0);
      OP_CLEAR:      clear_deque();
      default:       ;
    endcase
    view.front_value   = (front_idx != 0) ? val_mem[front_idx] : '0;
    view.back_value    = (back_idx != 0) ? val_mem[back_idx] : '0;
    view.is_empty      = (front_idx == 0);
    view.is_full       = (held >= NODES);
    view.element_count = held[7:0];
    view.status        = st;
    return view;
  endfunction

  task automatic compare_view(input xld_result_t got, input xld_result_t want);
    if (got.front_value !== want.front_value)
      log_mismatch("front_value", got.front_value, want.front_value);
    if (got.back_value !== want.back_value)
      log_mismatch("back_value", got.back_value, want.back_value);
    if (got.is_empty !== want.is_empty)
      log_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
    if (got.is_full !== want.is_full)
      log_mismatch("is_full", 32'(got.is_full), 32'(want.is_full));
    if (got.element_count !== want.element_count)
      log_mismatch("element_count", 32'(got.element_count), 32'(want.element_count));
    if (got.status !== want.status)
      log_mismatch("status", 32'(got.status), 32'(want.status));
    if (want.status == ST_FULL) full_seen = full_seen + 1;
    if (want.status == ST_EMPTY) empty_seen = empty_seen + 1;
    checked = checked + 1;
  endtask

  // result beat first, then a command beat taken at the same edge
  always @(posedge clk) begin
    if (rst) begin
      clear_deque();
      owed_views.delete();
    end else begin
      if (done) begin
        if (owed_views.size() == 0) begin
          log_mismatch("result beat with nothing owed", 32'(result.status), '0);
        end else begin
          oldest_view = owed_views[0];
          owed_views.delete(0);
          compare_view(result, oldest_view);
        end
      end
      if (start && !busy)
        owed_views.insert(owed_views.size(), apply_deque_op(command));
    end
    pending <= owed_views.size();
  end

endmodule

// File: dv/xor_linked_deque_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_linked_deque_tb
// Drives command beats into the xor-linked deque: a directed set covering the
// operation codes, value extremes, pops on empty and clears, then random
// blocks that fill the pool past full, drain it past empty and mix freely.
// The checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module xor_linked_deque_tb
  import xld_pkg::*;
();

  localparam int NODES      = DEF_NODES;
  localparam int TOTAL_CMDS = 950;

  // codes the block treats as no operation
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  // random block flavors
  localparam int MIX_FILL  = 0;
  localparam int MIX_DRAIN = 1;
  localparam int MIX_EVEN  = 2;
  localparam int MIX_NOISE = 3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  xld_cmd_t    command = '0;
  logic        done;
  xld_result_t result;

  int failures;
  int pending;
  int checked;
  int full_seen;
  int empty_seen;
  int sent = 0;
  bit no_gaps = 1'b0;

  xor_linked_deque #(.NODES(NODES)) dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .command (command),
    .done    (done),
    .result  (result)
  );

  xor_linked_deque_checker #(.NODES(NODES)) chk (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .done       (done),
    .result     (result),
    .failures   (failures),
    .pending    (pending),
    .checked    (checked),
    .full_seen  (full_seen),
    .empty_seen (empty_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d result beats owed", pending);
    $display("Some tests failed");
    $finish;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 15))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sh0;
      3: return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  // present one command beat, hold it until taken, then idle for the picked gap, if any
  task automatic issue_cmd(input logic [2:0] op, input logic signed [31:0] val);
    xld_cmd_t beat;
    int       gap;
    beat.operation = op;
    beat.value     = val;
    command <= beat;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent = sent + 1;
    gap = pick_gap();
    if (gap > 0) begin
      start             <= 1'b0;
      command.operation <= 3'($urandom());
      command.value     <= $urandom();
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic issue_push(input logic signed [31:0] val);
    issue_cmd($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, val);
  endtask

  task automatic issue_pop();
    issue_cmd($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, pick_value());
  endtask

  // a run of commands of one flavor: leaning to pushes or pops, even, or noise
  task automatic run_block(input int flavor, input int len);
    int r;
    no_gaps = ($urandom_range(0, 3) == 0);
    repeat (len) begin
      r = $urandom_range(0, 99);
      case (flavor)
        MIX_FILL:  if (r < 96) issue_push(pick_value()); else issue_pop();
        MIX_DRAIN: if (r < 96) issue_pop(); else issue_push(pick_value());
        MIX_EVEN: begin
          if (r < 2) issue_cmd(OP_CLEAR, pick_value());
          else if (r < 51) issue_push(pick_value());
          else issue_pop();
        end
        default: issue_cmd(3'($urandom_range(0, 7)), pick_value());
      endcase
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    int limit;
    int flavor;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty pops, value extremes, both ends, unused codes, clears
    issue_cmd(OP_POP_FRONT, 32'sh0);
    issue_cmd(OP_POP_BACK, -32'sd1);
    issue_cmd(OP_PUSH_FRONT, 32'sh7fffffff);
    issue_cmd(OP_PUSH_BACK, 32'sh80000000);
    issue_cmd(OP_PUSH_FRONT, -32'sd1);
    issue_cmd(OP_PUSH_BACK, 32'sh0);
    issue_cmd(OP_POP_FRONT, 32'sh0);
    issue_cmd(OP_POP_BACK, 32'sh0);
    issue_cmd(OP_POP_BACK, 32'sh0);
    issue_cmd(OP_POP_FRONT, 32'sh0);
    issue_cmd(OP_POP_FRONT, 32'sh0);
    issue_cmd(OP_PUSH_BACK, 32'sh55555555);
    issue_cmd(OP_PUSH_FRONT, 32'shaaaaaaaa);
    issue_cmd(OP_RSVD5, 32'sh1);
    issue_cmd(OP_RSVD6, 32'sh2);
    issue_cmd(OP_RSVD7, -32'sd3);
    issue_cmd(OP_CLEAR, 32'sh0);
    issue_cmd(OP_CLEAR, 32'sh0);
    issue_cmd(OP_PUSH_BACK, 32'sh1);
    issue_cmd(OP_POP_FRONT, 32'sh0);
    issue_cmd(OP_PUSH_FRONT, 32'sh2);
    issue_cmd(OP_POP_BACK, 32'sh0);
    issue_cmd(OP_PUSH_BACK, 32'sh3);
    issue_cmd(OP_PUSH_BACK, 32'sh4);
    issue_cmd(OP_POP_FRONT, 32'sh0);

    // random: fill past full, drain past empty, then mixed blocks
    run_block(MIX_FILL, 300);
    run_block(MIX_DRAIN, 300);
    while (sent < TOTAL_CMDS - 30) begin
      case ($urandom_range(0, 9))
        0, 1, 2: flavor = MIX_FILL;
        3, 4:    flavor = MIX_DRAIN;
        5, 6, 7: flavor = MIX_EVEN;
        default: flavor = MIX_NOISE;
      endcase
      run_block(flavor, $urandom_range(5, 60));
    end
    start <= 1'b0;

    // drain the owed results, then idle before the verdict
    limit = 0;
    @(posedge clk);
    while (pending != 0 && limit < 1000) begin
      @(posedge clk);
      limit = limit + 1;
    end
    repeat (8) @(posedge clk);
    if (pending != 0)
      $display("%0d result beats never arrived", pending);

    $display("run covered %0d commands, %0d result beats checked", sent, checked);
    $display("pushes refused on a full pool: %0d, pops on an empty list: %0d",
             full_seen, empty_seen);
    if (failures == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: xor_linked_deque.f
sv/xld_pkg.sv
sv/xld_node_mem.sv
sv/xld_free_stack.sv
sv/xor_linked_deque.sv
sv/xld_checker.sv
dv/xor_linked_deque_checker.sv
dv/xor_linked_deque_tb.sv
